@@ src/mwdem_pkg.sv @@
`timescale 1ns / 1ps

package mwdem_pkg;

  // Store geometry
  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = COL_W + ROW_W;
  localparam int DEPTH    = 1 << ADDR_W;

  // Largest usable area, limited by the 6-bit walker coordinates
  localparam int COLS_LIM_I = (MAX_COLS < 64) ? MAX_COLS : 64;
  localparam int ROWS_LIM_I = (MAX_ROWS < 64) ? MAX_ROWS : 64;
  localparam logic [6:0] COLS_LIM = 7'(COLS_LIM_I);
  localparam logic [6:0] ROWS_LIM = 7'(ROWS_LIM_I);

  typedef logic [1:0] kind_t;
  typedef logic [2:0] status_t;
  typedef logic [5:0] coord_t;
  typedef logic [6:0] extent_t;
  typedef logic [1:0] cfg_idx_t;
  typedef logic [ADDR_W-1:0] addr_t;

  // Cell kinds
  localparam kind_t K_OPEN   = 2'd0;
  localparam kind_t K_WALL   = 2'd1;
  localparam kind_t K_EXIT   = 2'd2;
  localparam kind_t K_PASSED = 2'd3;

  // Result status codes
  localparam status_t ST_MOVED = 3'd0;
  localparam status_t ST_EXIT  = 3'd1;
  localparam status_t ST_STUCK = 3'd2;
  localparam status_t ST_QUIT  = 3'd3;
  localparam status_t ST_DONE  = 3'd4;

  // Register indexes
  localparam cfg_idx_t CFG_MAZE_COLS = 2'd0;
  localparam cfg_idx_t CFG_MAZE_ROWS = 2'd1;
  localparam cfg_idx_t CFG_START_COL = 2'd2;
  localparam cfg_idx_t CFG_START_ROW = 2'd3;

  // Item request types
  localparam logic REQ_WRITE = 1'b0;

  function automatic addr_t cell_addr(input coord_t col, input coord_t row);
    cell_addr = {ROW_W'(row), COL_W'(col)};
  endfunction

  function automatic logic is_blocked(input kind_t k);
    is_blocked = (k == K_WALL) || (k == K_PASSED);
  endfunction

endpackage

@@ src/maze_walker_dead_end_marking.sv @@
`timescale 1ns / 1ps

// Maze walker with dead-end marking.
// Input items arrive on start/in_* and are taken when start is high and busy
// is low. A write item (in_req_type 0) stores one cell kind and returns the
// walker to the configured start; a step item (in_req_type 1) walks one cell.
// Each item yields exactly one result on out_*, marked by a one-cycle
// out_valid pulse; the receiver cannot stall it.
// Registers are written through cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high. Write registers only while the block is idle.
// A write item, a quit, a step after the walk has ended and a step from
// outside the area give their result in the cycle after acceptance, and busy
// stays low. A normal step reads the four neighbours, decides, marks and
// moves; a dead end with passed marks adds a pass that clears them before
// marking. Every neighbour read and every mark written goes through the single
// port of the maze memory, one access per cycle. After reset the maze memory
// is cleared to open cells, one cell per cycle, which holds busy high until
// every cell is written; configuration writes are taken during that pass.
module maze_walker_dead_end_marking (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  mwdem_pkg::coord_t    in_cell_col,
  input  mwdem_pkg::coord_t    in_cell_row,
  input  mwdem_pkg::kind_t     in_cell_kind,
  input  logic                 in_quit,
  output logic                 out_valid,
  output mwdem_pkg::status_t   out_status,
  output mwdem_pkg::coord_t    out_walker_col,
  output mwdem_pkg::coord_t    out_walker_row,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  mwdem_pkg::cfg_idx_t  cfg_index,
  input  logic [6:0]           cfg_data
);
  import mwdem_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_LAST, S_DECIDE, S_CLR, S_MARK, S_MOVE
  } state_t;

  state_t  state_r, state_nxt;
  logic [1:0] d_r, d_nxt;
  addr_t   clr_addr_r, clr_addr_nxt;
  coord_t  pos_col_r, pos_col_nxt, pos_row_r, pos_row_nxt;
  coord_t  prev_col_r, prev_col_nxt, prev_row_r, prev_row_nxt;
  coord_t  last_col_r, last_col_nxt, last_row_r, last_row_nxt;
  logic    finished_r, finished_nxt;
  logic    mark_r, mark_nxt;
  kind_t   kind_r [4];
  kind_t   kind_nxt [4];
  extent_t cols_r, cols_nxt, rows_r, rows_nxt;
  coord_t  scol_r, scol_nxt, srow_r, srow_nxt;
  logic    out_valid_r, out_valid_nxt;
  status_t out_status_r, out_status_nxt;
  coord_t  out_col_r, out_col_nxt, out_row_r, out_row_nxt;

  // Maze memory port
  kind_t   mem [DEPTH];
  kind_t   rd_data_r;
  logic    mem_we;
  addr_t   mem_addr;
  kind_t   mem_wdata;

  // Derived geometry
  extent_t used_cols, used_rows;
  coord_t  eff_scol, eff_srow;
  logic    in_area;
  logic [3:0] inb;
  coord_t  nb_col [4];
  coord_t  nb_row [4];

  // Decision helpers
  logic [3:0] blk, psd;
  logic [2:0] blk_cnt;
  logic    found;
  logic [1:0] sel;
  logic    accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_walker_col = out_col_r;
  assign out_walker_row = out_row_r;

  // Clamp the area and the start cell
  always_comb begin
    if (cols_r == 7'd0) used_cols = 7'd1;
    else if (cols_r > COLS_LIM) used_cols = COLS_LIM;
    else used_cols = cols_r;
    if (rows_r == 7'd0) used_rows = 7'd1;
    else if (rows_r > ROWS_LIM) used_rows = ROWS_LIM;
    else used_rows = rows_r;
    eff_scol = ({1'b0, scol_r} < used_cols) ? scol_r : 6'(used_cols - 7'd1);
    eff_srow = ({1'b0, srow_r} < used_rows) ? srow_r : 6'(used_rows - 7'd1);
    in_area = ({1'b0, pos_col_r} < used_cols) && ({1'b0, pos_row_r} < used_rows);
  end

  // Neighbours in the order right, down, left, up
  always_comb begin
    inb[0] = ({1'b0, pos_col_r} + 7'd1) < used_cols;
    inb[1] = ({1'b0, pos_row_r} + 7'd1) < used_rows;
    inb[2] = (pos_col_r != 6'd0);
    inb[3] = (pos_row_r != 6'd0);
    nb_col[0] = pos_col_r + 6'd1;  nb_row[0] = pos_row_r;
    nb_col[1] = pos_col_r;         nb_row[1] = pos_row_r + 6'd1;
    nb_col[2] = pos_col_r - 6'd1;  nb_row[2] = pos_row_r;
    nb_col[3] = pos_col_r;         nb_row[3] = pos_row_r - 6'd1;
  end

  // Classify the gathered neighbours and pick the first free one
  always_comb begin
    found = 1'b0;
    sel   = 2'd0;
    for (int i = 0; i < 4; i++) begin
      blk[i] = inb[i] && is_blocked(kind_r[i]);
      psd[i] = inb[i] && (kind_r[i] == K_PASSED);
    end
    blk_cnt = 3'($countones(blk));
    for (int i = 3; i >= 0; i--) begin
      if (inb[i] && !is_blocked(kind_r[i])) begin
        found = 1'b1;
        sel   = 2'(i);
      end
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    d_nxt          = d_r;
    clr_addr_nxt   = clr_addr_r;
    pos_col_nxt    = pos_col_r;
    pos_row_nxt    = pos_row_r;
    prev_col_nxt   = prev_col_r;
    prev_row_nxt   = prev_row_r;
    last_col_nxt   = last_col_r;
    last_row_nxt   = last_row_r;
    finished_nxt   = finished_r;
    mark_nxt       = mark_r;
    for (int i = 0; i < 4; i++) kind_nxt[i] = kind_r[i];
    cols_nxt       = cols_r;
    rows_nxt       = rows_r;
    scol_nxt       = scol_r;
    srow_nxt       = srow_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    mem_we         = 1'b0;
    mem_addr       = cell_addr(nb_col[d_r], nb_row[d_r]);
    mem_wdata      = K_OPEN;

    // Take register writes at any time
    if (cfg_valid) begin
      case (cfg_index)
        CFG_MAZE_COLS: cols_nxt = cfg_data;
        CFG_MAZE_ROWS: rows_nxt = cfg_data;
        CFG_START_COL: scol_nxt = cfg_data[5:0];
        CFG_START_ROW: srow_nxt = cfg_data[5:0];
        default: ;
      endcase
    end

    case (state_r)
      // Sweep the memory to open cells
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        clr_addr_nxt = clr_addr_r + addr_t'(1);
        if (clr_addr_r == '1) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_col_nxt   = pos_col_r;
          out_row_nxt   = pos_row_r;
          if (in_req_type == REQ_WRITE) begin
            // Store the cell and restart the walk
            mem_addr  = cell_addr(in_cell_col, in_cell_row);
            mem_wdata = in_cell_kind;
            mem_we    = (32'(in_cell_col) < MAX_COLS) && (32'(in_cell_row) < MAX_ROWS);
            pos_col_nxt    = eff_scol;
            pos_row_nxt    = eff_srow;
            prev_col_nxt   = eff_scol;
            prev_row_nxt   = eff_srow;
            finished_nxt   = 1'b0;
            out_status_nxt = ST_MOVED;
            out_col_nxt    = eff_scol;
            out_row_nxt    = eff_srow;
          end else if (finished_r) begin
            out_status_nxt = ST_DONE;
          end else if (in_quit) begin
            finished_nxt   = 1'b1;
            out_status_nxt = ST_QUIT;
          end else if (!in_area) begin
            finished_nxt   = 1'b1;
            out_status_nxt = ST_STUCK;
          end else begin
            // Begin a step: gather the four neighbours
            out_valid_nxt = 1'b0;
            last_col_nxt  = prev_col_r;
            last_row_nxt  = prev_row_r;
            prev_col_nxt  = pos_col_r;
            prev_row_nxt  = pos_row_r;
            d_nxt         = 2'd0;
            state_nxt     = S_READ;
          end
        end
      end

      // Issue one neighbour read a cycle, capture the one before
      S_READ: begin
        if (d_r != 2'd0) kind_nxt[d_r - 2'd1] = rd_data_r;
        d_nxt = d_r + 2'd1;
        if (d_r == 2'd3) state_nxt = S_LAST;
      end

      S_LAST: begin
        kind_nxt[3] = rd_data_r;
        state_nxt   = S_DECIDE;
      end

      S_DECIDE: begin
        mark_nxt = (blk_cnt >= 3'd3);
        if (blk == 4'hF) begin
          if (psd == 4'h0) begin
            finished_nxt   = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_STUCK;
            out_col_nxt    = pos_col_r;
            out_row_nxt    = pos_row_r;
            state_nxt      = S_IDLE;
          end else begin
            d_nxt     = 2'd0;
            state_nxt = S_CLR;
          end
        end else begin
          state_nxt = S_MARK;
        end
      end

      // Drop passed marks around a dead end
      S_CLR: begin
        mem_wdata = K_OPEN;
        if (psd[d_r]) begin
          mem_we        = 1'b1;
          kind_nxt[d_r] = K_OPEN;
        end
        d_nxt = d_r + 2'd1;
        if (d_r == 2'd3) state_nxt = S_MARK;
      end

      // Mark the current cell as passed if three or more neighbours are blocked
      S_MARK: begin
        mem_addr  = cell_addr(pos_col_r, pos_row_r);
        mem_wdata = K_PASSED;
        mem_we    = mark_r;
        state_nxt = S_MOVE;
      end

      // Advance to the first free neighbour, or report stuck if there is none
      S_MOVE: begin
        mem_addr      = cell_addr(nb_col[sel], nb_row[sel]);
        mem_wdata     = K_PASSED;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (!found) begin
          finished_nxt   = 1'b1;
          out_status_nxt = ST_STUCK;
          out_col_nxt    = pos_col_r;
          out_row_nxt    = pos_row_r;
        end else begin
          pos_col_nxt = nb_col[sel];
          pos_row_nxt = nb_row[sel];
          out_col_nxt = nb_col[sel];
          out_row_nxt = nb_row[sel];
          if (kind_r[sel] == K_EXIT) begin
            finished_nxt   = 1'b1;
            out_status_nxt = ST_EXIT;
          end else begin
            out_status_nxt = ST_MOVED;
            mem_we = (nb_col[sel] == last_col_r) && (nb_row[sel] == last_row_r);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      d_r         <= 2'd0;
      clr_addr_r  <= '0;
      pos_col_r   <= 6'd0;
      pos_row_r   <= 6'd0;
      prev_col_r  <= 6'd0;
      prev_row_r  <= 6'd0;
      finished_r  <= 1'b0;
      cols_r      <= COLS_LIM;
      rows_r      <= ROWS_LIM;
      scol_r      <= 6'd0;
      srow_r      <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      d_r         <= d_nxt;
      clr_addr_r  <= clr_addr_nxt;
      pos_col_r   <= pos_col_nxt;
      pos_row_r   <= pos_row_nxt;
      prev_col_r  <= prev_col_nxt;
      prev_row_r  <= prev_row_nxt;
      finished_r  <= finished_nxt;
      cols_r      <= cols_nxt;
      rows_r      <= rows_nxt;
      scol_r      <= scol_nxt;
      srow_r      <= srow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_col_r   <= last_col_nxt;
    last_row_r   <= last_row_nxt;
    mark_r       <= mark_nxt;
    for (int i = 0; i < 4; i++) kind_r[i] <= kind_nxt[i];
    out_status_r <= out_status_nxt;
    out_col_r    <= out_col_nxt;
    out_row_r    <= out_row_nxt;
  end

  // Single-port maze memory with registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

endmodule
